FILE: rtl/assert_macros.svh
// assertion macros shared by the key sorter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property that holds at every clock edge out of reset
`define KS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// antecedent in this cycle implies consequent in the next
`define KS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define KS_ASSERT(lbl, clk, rstn, prop, msg)
`define KS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: rtl/ks_pkg.sv
// types and constants of the key sorter
package ks_pkg;

  localparam int KEY_BITS_DEF  = 32;
  localparam int MAX_ITEMS_DEF = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_KEYS = 2'd1;

  typedef struct packed {
    logic [31:0] key;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] sorted_key;
    logic        end_of_run;
    logic        dropped_items;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_DRAIN
  } ks_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SORT,
    CELL_DRAIN
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
    logic     descending;
    logic     signed_keys;
  } cell_ctrl_t;

endpackage

FILE: rtl/key_sorter_unit.sv
// key sorter top level: chain of sorting cells with its sequencer and output register
//
// input channel (in_valid, in_stall, in_data): one key per word; the word with
// last set closes the set. keys are accepted one per cycle while loading; once
// MAX_ITEMS keys are held, further keys of the set are dropped and flagged.
// after the closing word the chain runs count odd-even transposition rounds,
// one per cycle, then the sorted keys leave through out_valid, out_stall and
// out_data, one per cycle while not stalled, lowest order value first;
// end_of_run marks the last key and dropped_items is set on every key of a
// set that lost keys. the sort length is set by the neighbor-exchange rounds
// of the cell chain. the first sorted key is valid once the sort rounds have
// ended and the first drain step has moved cell 0 into the output register.
// in_stall stays high from the closing word until the last key of the run
// has moved into the output register.
// a stalled receiver holds the output register and freezes the drain shift.
// configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// the order in force when the closing word arrives decides the whole run.
// reset (rst_n low, synchronous) empties the set, clears the overflow flag
// and out_valid, and selects unsigned ascending order.
`include "assert_macros.svh"
module key_sorter_unit import ks_pkg::*; #(
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  // configuration port
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  // configuration registers
  logic desc_r, desc_nxt;
  logic sgn_r, sgn_nxt;

  // handshakes
  logic in_fire;
  logic out_free;
  logic drain_fire;
  logic drain_last;
  logic overflow;

  cell_ctrl_t       cell_ctrl;
  logic [CNT_W-1:0] count;

  // chain wiring
  logic [KEY_BITS-1:0] cell_key [MAX_ITEMS];
  logic                cell_swap [MAX_ITEMS];
  logic [KEY_BITS+31:0] key_in_wide;
  logic [KEY_BITS-1:0]  key_in;
  logic [KEY_BITS+31:0] key_out_wide;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    desc_nxt = desc_r;
    sgn_nxt  = sgn_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_DESCENDING:  desc_nxt = cfg_data[0];
        REG_SIGNED_KEYS: sgn_nxt  = cfg_data[0];
        default: begin
          // writes beyond the register list are ignored
          desc_nxt = desc_r;
          sgn_nxt  = sgn_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
      sgn_r  <= 1'b0;
    end else begin
      desc_r <= desc_nxt;
      sgn_r  <= sgn_nxt;
    end
  end

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // keep only the low KEY_BITS bits of the incoming key
  assign key_in_wide = {{KEY_BITS{1'b0}}, in_data.key};
  assign key_in      = key_in_wide[KEY_BITS-1:0];

  ks_ctrl #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_last        (in_data.last),
    .cfg_descending (desc_r),
    .cfg_signed_keys(sgn_r),
    .out_free       (out_free),
    .cell_ctrl      (cell_ctrl),
    .count          (count),
    .in_stall       (in_stall),
    .drain_fire     (drain_fire),
    .drain_last     (drain_last),
    .overflow       (overflow)
  );

  // new keys enter at cell 0 and push the chain up; the drain pulls it down
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic [KEY_BITS-1:0] left_key;
    logic [KEY_BITS-1:0] right_key;
    logic                swap_left;

    if (i == 0) begin : g_first
      assign left_key  = key_in;
      assign swap_left = 1'b0;
    end else begin : g_inner
      assign left_key  = cell_key[i-1];
      assign swap_left = cell_swap[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_top
      assign right_key = '0;
    end else begin : g_below
      assign right_key = cell_key[i+1];
    end

    ks_cell #(
      .KEY_BITS (KEY_BITS),
      .MAX_ITEMS(MAX_ITEMS),
      .IDX      (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .count    (count),
      .left_key (left_key),
      .right_key(right_key),
      .swap_in  (swap_left),
      .key_o    (cell_key[i]),
      .swap_o   (cell_swap[i])
    );
  end

  // during the drain, cell 0 holds the next key of the sorted run
  assign key_out_wide = {32'b0, cell_key[0]};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (drain_fire) begin
      out_valid_nxt              = 1'b1;
      out_word_nxt.sorted_key    = key_out_wide[31:0];
      out_word_nxt.end_of_run    = drain_last;
      out_word_nxt.dropped_items = overflow;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

FILE: rtl/ks_cell.sv
// one cell of the sorting chain: holds a key, shifts or compare-exchanges with neighbors
module ks_cell import ks_pkg::*; #(
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int MAX_ITEMS = MAX_ITEMS_DEF,
  parameter int IDX       = 0,
  localparam int CNT_W    = $clog2(MAX_ITEMS + 1)
) (
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic [CNT_W-1:0]    count,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic [KEY_BITS-1:0] right_key,
  input  logic                swap_in,
  output logic [KEY_BITS-1:0] key_o,
  output logic                swap_o
);

  localparam logic [KEY_BITS-1:0] MSB     = KEY_BITS'(1) << (KEY_BITS - 1);
  localparam logic                IDX_ODD = ((IDX % 2) == 1);
  localparam logic [CNT_W-1:0]    IDX_P1  = CNT_W'(IDX + 1);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [KEY_BITS-1:0] self_ov, right_ov, flip;
  logic                lower_en;

  // map to a value whose unsigned order is the selected order
  assign flip     = (ctrl.signed_keys ? MSB : '0) ^ {KEY_BITS{ctrl.descending}};
  assign self_ov  = key_r ^ flip;
  assign right_ov = right_key ^ flip;

  // this cell is the lower one of an active pair
  assign lower_en = (ctrl.phase == IDX_ODD) && (count > IDX_P1);
  assign swap_o   = (ctrl.op == CELL_SORT) && lower_en && (self_ov > right_ov);

  always_comb begin
    unique case (ctrl.op)
      CELL_LOAD:  key_nxt = left_key;
      CELL_DRAIN: key_nxt = right_key;
      CELL_SORT: begin
        if (swap_o) begin
          key_nxt = right_key;
        end else if (swap_in) begin
          key_nxt = left_key;
        end else begin
          key_nxt = key_r;
        end
      end
      default:    key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_o = key_r;

endmodule

FILE: rtl/ks_ctrl.sv
// sequencer of the key sorter: load, odd-even sort rounds, drain
`include "assert_macros.svh"
module ks_ctrl import ks_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF,
  localparam int CNT_W    = $clog2(MAX_ITEMS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             in_last,
  input  logic             cfg_descending,
  input  logic             cfg_signed_keys,
  input  logic             out_free,
  output cell_ctrl_t       cell_ctrl,
  output logic [CNT_W-1:0] count,
  output logic             in_stall,
  output logic             drain_fire,
  output logic             drain_last,
  output logic             overflow
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  ks_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] round_r, round_nxt;
  logic             ovf_r, ovf_nxt;
  logic             desc_r, desc_nxt;
  logic             sgn_r, sgn_nxt;
  logic             full;
  logic             sort_done;

  assign full      = (count_r == CNT_MAX);
  assign sort_done = (round_r == count_r - CNT_ONE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_fire && in_last) begin
          state_nxt = ST_SORT;
        end
      end
      ST_SORT: begin
        if (sort_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_fire && drain_last) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    cell_ctrl.op          = CELL_HOLD;
    cell_ctrl.phase       = round_r[0];
    cell_ctrl.descending  = desc_r;
    cell_ctrl.signed_keys = sgn_r;
    in_stall              = 1'b1;
    drain_fire            = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_fire && !full) begin
          cell_ctrl.op = CELL_LOAD;
        end
      end
      ST_SORT: cell_ctrl.op = CELL_SORT;
      ST_DRAIN: begin
        if (out_free) begin
          cell_ctrl.op = CELL_DRAIN;
          drain_fire   = 1'b1;
        end
      end
      default: cell_ctrl.op = CELL_HOLD;
    endcase
  end

  assign drain_last = (count_r == CNT_ONE);
  assign count      = count_r;
  assign overflow   = ovf_r;

  // counters and latched order
  always_comb begin
    count_nxt = count_r;
    round_nxt = round_r;
    ovf_nxt   = ovf_r;
    desc_nxt  = desc_r;
    sgn_nxt   = sgn_r;
    if (cell_ctrl.op == CELL_LOAD) begin
      count_nxt = count_r + CNT_ONE;
    end else if (drain_fire) begin
      count_nxt = count_r - CNT_ONE;
    end
    if (state_r == ST_LOAD && in_fire && full) begin
      ovf_nxt = 1'b1;
    end else if (drain_fire && drain_last) begin
      ovf_nxt = 1'b0;
    end
    if (state_r == ST_SORT) begin
      round_nxt = round_r + CNT_ONE;
    end else begin
      round_nxt = '0;
    end
    if (state_r == ST_LOAD && in_fire && in_last) begin
      desc_nxt = cfg_descending;
      sgn_nxt  = cfg_signed_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      round_r <= '0;
      ovf_r   <= 1'b0;
      desc_r  <= 1'b0;
      sgn_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      round_r <= round_nxt;
      ovf_r   <= ovf_nxt;
      desc_r  <= desc_nxt;
      sgn_r   <= sgn_nxt;
    end
  end

  `KS_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_MAX, "item count above capacity")
  `KS_ASSERT(a_nonempty_run, clk, rst_n, (state_r == ST_LOAD) || (count_r != '0), "sort or drain with empty chain")
  `KS_ASSERT_NEXT(a_run_closes, clk, rst_n, drain_fire && drain_last, (state_r == ST_LOAD) && (count_r == '0) && !ovf_r, "run did not return to an empty set")
  `KS_ASSERT_NEXT(a_sort_to_drain, clk, rst_n, (state_r == ST_SORT) && sort_done, state_r == ST_DRAIN, "sort rounds did not end in drain")

endmodule
